>>> rtl/mlfc_pkg.sv
// ----------------------------------------------------------------------------
// mlfc_pkg
// Shared types and constants for the marker/length frame checker.
// ----------------------------------------------------------------------------
package mlfc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'h66;
  localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'h16;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 1'b1;

  typedef enum logic [2:0] {
    PH_START1 = 3'd0,
    PH_LEN1   = 3'd1,
    PH_LEN2   = 3'd2,
    PH_START2 = 3'd3,
    PH_BODY   = 3'd4,
    PH_SUM    = 3'd5,
    PH_END    = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    V_NONE   = 3'd0,
    V_GOOD   = 3'd1,
    V_HEADER = 3'd2,
    V_SUM    = 3'd3,
    V_END    = 3'd4,
    V_TRUNC  = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    verdict_t          verdict;
    logic [BYTE_W-1:0] body_length;
  } out_t;

endpackage

>>> rtl/mlfc_tracker.sv
// ----------------------------------------------------------------------------
// mlfc_tracker
// Frame phase tracker: holds the per-frame state and forms one result word
// for every accepted byte.
// ----------------------------------------------------------------------------
module mlfc_tracker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  mlfc_pkg::in_t              word,
  input  logic [mlfc_pkg::BYTE_W-1:0] start_marker,
  input  logic [mlfc_pkg::BYTE_W-1:0] end_marker,
  output mlfc_pkg::out_t             result
);

  mlfc_pkg::phase_t            phase, phase_next;
  logic [mlfc_pkg::BYTE_W-1:0] first_length, first_length_next;
  logic [mlfc_pkg::BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [mlfc_pkg::BYTE_W-1:0] running_sum, running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mlfc_pkg::PH_START1;
      first_length <= '0;
      bytes_left   <= '0;
      running_sum  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      first_length <= first_length_next;
      bytes_left   <= bytes_left_next;
      running_sum  <= running_sum_next;
    end
  end

  always_comb begin
    mlfc_pkg::verdict_t verd;
    logic [mlfc_pkg::BYTE_W-1:0] b;
    b                 = word.data_byte;
    verd              = mlfc_pkg::V_NONE;
    phase_next        = phase;
    first_length_next = first_length;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    result.payload_byte  = '0;
    result.payload_valid = 1'b0;

    unique case (phase)
      mlfc_pkg::PH_START1: begin
        if (b != start_marker) verd = mlfc_pkg::V_HEADER;
        else phase_next = mlfc_pkg::PH_LEN1;
      end
      mlfc_pkg::PH_LEN1: begin
        first_length_next = b;
        phase_next        = mlfc_pkg::PH_LEN2;
      end
      mlfc_pkg::PH_LEN2: begin
        if (b != first_length) begin
          verd = mlfc_pkg::V_HEADER;
        end else begin
          bytes_left_next = b;
          phase_next      = mlfc_pkg::PH_START2;
        end
      end
      mlfc_pkg::PH_START2: begin
        if (b != start_marker) begin
          verd = mlfc_pkg::V_HEADER;
        end else begin
          running_sum_next = '0;
          phase_next = (bytes_left == '0) ? mlfc_pkg::PH_SUM : mlfc_pkg::PH_BODY;
        end
      end
      mlfc_pkg::PH_BODY: begin
        result.payload_byte  = b;
        result.payload_valid = 1'b1;
        running_sum_next     = running_sum + b;
        bytes_left_next      = bytes_left - 1'b1;
        if (bytes_left_next == '0) phase_next = mlfc_pkg::PH_SUM;
      end
      mlfc_pkg::PH_SUM: begin
        if (b != running_sum) verd = mlfc_pkg::V_SUM;
        else phase_next = mlfc_pkg::PH_END;
      end
      mlfc_pkg::PH_END: begin
        verd = (b == end_marker) ? mlfc_pkg::V_GOOD : mlfc_pkg::V_END;
      end
      mlfc_pkg::PH_DONE: begin
        // ignore bytes after a verdict
      end
      default: begin
      end
    endcase

    if (verd != mlfc_pkg::V_NONE) phase_next = mlfc_pkg::PH_DONE;
    else if (word.last_byte && phase_next != mlfc_pkg::PH_DONE) verd = mlfc_pkg::V_TRUNC;

    result.verdict     = verd;
    result.body_length = (verd != mlfc_pkg::V_NONE) ? first_length_next : '0;

    // end of buffer: start over at offset zero
    if (word.last_byte) begin
      phase_next        = mlfc_pkg::PH_START1;
      first_length_next = '0;
      bytes_left_next   = '0;
      running_sum_next  = '0;
    end
  end

endmodule

>>> rtl/marker_length_frame_checker_core.sv
// ----------------------------------------------------------------------------
// marker_length_frame_checker_core
// Result word registered: it shows in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless a result sits unclaimed; the phase
// tracker is combinational; the result register frees once its word is taken.
// Reset (rst, synchronous): frame state to start, output empty, markers to
// 0x66 / 0x16.
// ----------------------------------------------------------------------------
module marker_length_frame_checker_core (
  input  logic                              clk,
  input  logic                              rst,
  // byte channel
  input  logic                              byte_valid,
  output logic                              byte_stall,
  input  mlfc_pkg::in_t                     byte_word,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output mlfc_pkg::out_t                    result_word,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mlfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mlfc_pkg::BYTE_W-1:0]       cfg_data
);

  logic [mlfc_pkg::BYTE_W-1:0] start_marker;
  logic [mlfc_pkg::BYTE_W-1:0] end_marker;
  logic                        accept;
  mlfc_pkg::out_t              result;

  // Configuration writes are always accepted; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= mlfc_pkg::START_MARKER_RESET;
      end_marker   <= mlfc_pkg::END_MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mlfc_pkg::REG_START_MARKER: start_marker <= cfg_data;
        mlfc_pkg::REG_END_MARKER:   end_marker   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stall the byte side only while a finished word sits unclaimed; a word
  // taken this cycle makes room for the next byte in the same edge.
  assign byte_stall = result_valid && result_stall;
  assign accept     = byte_valid && !byte_stall;

  mlfc_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .word         (byte_word),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .result       (result)
  );

  // Result register: load on accept, drop once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_word <= result;
    end
  end

endmodule
